@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted insert priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int FILL_W = 5;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Broadcast to every cell in the chain.
    typedef struct packed
    {
        logic ins;
        logic rem;
    } cell_ctrl_t;

endpackage

@@ sv/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int KEY_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 32
)
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic                     occ,
    input  logic [KEY_WIDTH-1:0]     new_key,
    input  logic [PAYLOAD_WIDTH-1:0] new_payload,
    input  logic                     left_gt,
    input  logic [KEY_WIDTH-1:0]     left_key,
    input  logic [PAYLOAD_WIDTH-1:0] left_payload,
    input  logic [KEY_WIDTH-1:0]     right_key,
    input  logic [PAYLOAD_WIDTH-1:0] right_payload,
    output logic                     gt,
    output logic [KEY_WIDTH-1:0]     key,
    output logic [PAYLOAD_WIDTH-1:0] payload
);

    logic [KEY_WIDTH-1:0]     key_reg;
    logic [KEY_WIDTH-1:0]     key_next;
    logic [PAYLOAD_WIDTH-1:0] payload_reg;
    logic [PAYLOAD_WIDTH-1:0] payload_next;

    // An empty slot counts as greater, so the new item lands right after the tail.
    assign gt      = !occ || (new_key < key_reg);
    assign key     = key_reg;
    assign payload = payload_reg;

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctrl.ins && gt)
        begin
            if (left_gt)
            begin
                key_next     = left_key;
                payload_next = left_payload;
            end
            else
            begin
                key_next     = new_key;
                payload_next = new_payload;
            end
        end
        else if (ctrl.rem)
        begin
            key_next     = right_key;
            payload_next = right_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

endmodule

@@ sv/sorted_insert_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_core
// Bounded priority queue kept sorted by ascending key in a chain of cells.
//
//   Channel  Handshake             Payload
//   request  req_valid/req_stall   opcode, new_key, new_payload
//   response rsp_valid/rsp_stall   out_valid, out_key, out_payload, status,
//                                  fill_count
//
// Every cell compares against the new key in parallel, so an insert or a
// remove updates the chain as it is accepted and the response appears the cycle after.
// One item per cycle is sustained while the response side takes results.
// Reset empties the queue; the stored entries need no clearing.
// A held response stalls the request side only while it is not taken.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH         = 16,
    parameter int KEY_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic                     opcode,
    input  logic [KEY_WIDTH-1:0]     new_key,
    input  logic [PAYLOAD_WIDTH-1:0] new_payload,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic                     out_valid,
    output logic [KEY_WIDTH-1:0]     out_key,
    output logic [PAYLOAD_WIDTH-1:0] out_payload,
    output logic [1:0]               status,
    output logic [FILL_W-1:0]        fill_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                     accept;
    logic                     full;
    logic                     empty;
    cell_ctrl_t               ctrl;
    logic [DEPTH-1:0]         occ;
    logic [DEPTH-1:0]         gt;
    logic [KEY_WIDTH-1:0]     cell_key [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] cell_payload [DEPTH];

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    logic                     out_valid_reg;
    logic [KEY_WIDTH-1:0]     out_key_reg;
    logic [PAYLOAD_WIDTH-1:0] out_payload_reg;
    status_t                  status_reg;
    logic [CNT_W+FILL_W-1:0]  fill_wide;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign ctrl.ins  = accept && (opcode == OP_INSERT) && !full;
    assign ctrl.rem  = accept && (opcode == OP_REMOVE) && !empty;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                     l_gt;
            logic [KEY_WIDTH-1:0]     l_key;
            logic [PAYLOAD_WIDTH-1:0] l_payload;
            logic [KEY_WIDTH-1:0]     r_key;
            logic [PAYLOAD_WIDTH-1:0] r_payload;

            assign occ[i] = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign l_gt      = 1'b0;
                assign l_key     = new_key;
                assign l_payload = new_payload;
            end
            else
            begin : g_body
                assign l_gt      = gt[i-1];
                assign l_key     = cell_key[i-1];
                assign l_payload = cell_payload[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign r_key     = cell_key[i];
                assign r_payload = cell_payload[i];
            end
            else
            begin : g_inner
                assign r_key     = cell_key[i+1];
                assign r_payload = cell_payload[i+1];
            end

            spq_cell #(
                .KEY_WIDTH     (KEY_WIDTH),
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
            ) u_cell (
                .clk           (clk),
                .ctrl          (ctrl),
                .occ           (occ[i]),
                .new_key       (new_key),
                .new_payload   (new_payload),
                .left_gt       (l_gt),
                .left_key      (l_key),
                .left_payload  (l_payload),
                .right_key     (r_key),
                .right_payload (r_payload),
                .gt            (gt[i]),
                .key           (cell_key[i]),
                .payload       (cell_payload[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_valid_reg   <= ctrl.rem;
            out_key_reg     <= ctrl.rem ? cell_key[0] : '0;
            out_payload_reg <= ctrl.rem ? cell_payload[0] : '0;
            if ((opcode == OP_INSERT) && full)
            begin
                status_reg <= ST_FULL;
            end
            else if ((opcode == OP_REMOVE) && empty)
            begin
                status_reg <= ST_EMPTY;
            end
            else
            begin
                status_reg <= ST_DONE;
            end
        end
    end

    // The count register always holds the count after the last accepted item.
    assign fill_wide   = {{FILL_W{1'b0}}, count_reg};
    assign rsp_valid   = rsp_valid_reg;
    assign out_valid   = out_valid_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_payload_reg;
    assign status      = status_reg;
    assign fill_count  = fill_wide[FILL_W-1:0];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_remove_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_REMOVE) && !empty) |=> (rsp_valid && out_valid))
        else $error("remove from a non-empty queue returned no entry");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_INSERT) && !full)
            |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted insert did not grow the queue");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_key[0] <= cell_key[1]))
        else $error("head entries out of order");

endmodule

@@ tb/sv/tb_sorted_insert_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_insert_priority_queue_core
// Self-checking bench for the sorted insert priority queue.
//
// A scoreboard keeps its own sorted copy of the queue. Every request taken by
// the block updates that copy and queues the response it should produce.
// Every response taken from the block is compared with the oldest of those.
// Stimulus is a short directed run followed by random phases. The phases fill
// the queue past full and drain it past empty, mix inserts and removes with
// wide or narrow keys, and hold the response side off while requests keep
// coming. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb_sorted_insert_priority_queue_core
    import spq_pkg::*;
();

    localparam int DEPTH        = 16;
    localparam int KEY_W        = 16;
    localparam int PAY_W        = 32;
    localparam int HOLD_CYCLES  = 120;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TARGET_ITEMS = 1350;
    localparam int TAIL_CYCLES  = 8;

    typedef struct
    {
        logic             hit;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        status_t          st;
        logic [FILL_W-1:0] fill;
    } queue_answer_t;

    class spq_scoreboard;
        logic [KEY_W-1:0] keys [DEPTH];
        logic [PAY_W-1:0] pays [DEPTH];
        int               count;
        int               errors;
        queue_answer_t    pending_answers [$];

        // Applies one taken request to the sorted copy and queues its response.
        function void apply_request(opcode_t op, logic [KEY_W-1:0] k,
                                    logic [PAY_W-1:0] p);
            queue_answer_t a;
            int            pos;
            a.hit     = 1'b0;
            a.key     = '0;
            a.payload = '0;
            a.st      = ST_DONE;
            if (op == OP_INSERT)
            begin
                if (count >= DEPTH)
                begin
                    a.st = ST_FULL;
                end
                else
                begin
                    // Walk down from the tail; stopping at an equal key keeps
                    // entries with the same key in arrival order.
                    pos = count;
                    while (pos > 0 && keys[pos-1] > k)
                    begin
                        keys[pos] = keys[pos-1];
                        pays[pos] = pays[pos-1];
                        pos--;
                    end
                    keys[pos] = k;
                    pays[pos] = p;
                    count++;
                end
            end
            else
            begin
                if (count == 0)
                begin
                    a.st = ST_EMPTY;
                end
                else
                begin
                    a.hit     = 1'b1;
                    a.key     = keys[0];
                    a.payload = pays[0];
                    for (pos = 0; pos < count - 1; pos++)
                    begin
                        keys[pos] = keys[pos+1];
                        pays[pos] = pays[pos+1];
                    end
                    count--;
                end
            end
            a.fill = count[FILL_W-1:0];
            pending_answers.push_back(a);
        endfunction

        function void check_response(logic hit, logic [KEY_W-1:0] k,
                                     logic [PAY_W-1:0] p, logic [1:0] st,
                                     logic [FILL_W-1:0] fill);
            queue_answer_t a;
            if (pending_answers.size() == 0)
            begin
                $error("response with no request waiting: status %0d fill %0d", st, fill);
                errors++;
                return;
            end
            a = pending_answers.pop_front();
            if (hit !== a.hit)
            begin
                $error("out_valid: expected %0d, actual %0d", a.hit, hit);
                errors++;
            end
            if (k !== a.key)
            begin
                $error("out_key: expected %h, actual %h", a.key, k);
                errors++;
            end
            if (p !== a.payload)
            begin
                $error("out_payload: expected %h, actual %h", a.payload, p);
                errors++;
            end
            if (st !== a.st)
            begin
                $error("status: expected %0d, actual %0d", a.st, st);
                errors++;
            end
            if (fill !== a.fill)
            begin
                $error("fill_count: expected %0d, actual %0d", a.fill, fill);
                errors++;
            end
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    logic              opcode;
    logic [KEY_W-1:0]  new_key;
    logic [PAY_W-1:0]  new_payload;
    logic              rsp_valid;
    logic              rsp_stall;
    logic              out_valid;
    logic [KEY_W-1:0]  out_key;
    logic [PAY_W-1:0]  out_payload;
    logic [1:0]        status;
    logic [FILL_W-1:0] fill_count;

    spq_scoreboard sb;
    bit            no_idle;
    bit            hold_rsp;
    int            items_sent;
    int            idle_cycles;

    sorted_insert_priority_queue_core
    #(
        .DEPTH         (DEPTH),
        .KEY_WIDTH     (KEY_W),
        .PAYLOAD_WIDTH (PAY_W)
    )
    dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .opcode      (opcode),
        .new_key     (new_key),
        .new_payload (new_payload),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .out_valid   (out_valid),
        .out_key     (out_key),
        .out_payload (out_payload),
        .status      (status),
        .fill_count  (fill_count)
    );

    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        return $urandom_range(10, 45);
    endfunction

    // Wide random keys, a narrow range full of duplicates, or the extremes.
    function automatic logic [KEY_W-1:0] pick_key(int mode);
        int r;
        if (mode == 1)
            return KEY_W'($urandom_range(0, 7));
        if (mode == 2)
        begin
            r = $urandom_range(0, 2);
            if (r == 0)
                return '0;
            if (r == 1)
                return '1;
        end
        return KEY_W'($urandom);
    endfunction

    function automatic opcode_t pick_op(int insert_pct);
        return ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    endfunction

    task automatic send_item(opcode_t op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        opcode      <= op;
        new_key     <= k;
        new_payload <= p;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_for_answers();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // The response side stops taking results while requests keep coming, so
    // the held response backs up into the request side.
    task automatic pressure_burst();
        no_idle  = 1'b1;
        hold_rsp = 1'b1;
        repeat (30) send_item(pick_op(60), pick_key(0), $urandom);
        wait_for_answers();
    endtask

    task automatic run_phase();
        int kind;
        int mode;
        int bias;
        int n;
        kind    = $urandom_range(0, 9);
        mode    = $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 4) == 0);
        if (kind < 3)
        begin
            // Push past full, then pop past empty.
            n = DEPTH + $urandom_range(1, 3);
            repeat (n) send_item(OP_INSERT, pick_key(mode), $urandom);
            n = DEPTH + $urandom_range(1, 3);
            repeat (n) send_item(OP_REMOVE, pick_key(0), $urandom);
        end
        else if (kind < 8)
        begin
            n    = $urandom_range(20, 60);
            bias = $urandom_range(25, 80);
            repeat (n) send_item(pick_op(bias), pick_key(mode), $urandom);
        end
        else if (kind == 8)
        begin
            repeat ($urandom_range(10, 30)) send_item(pick_op(50), pick_key(0), $urandom);
        end
        else
        begin
            pressure_burst();
        end
        if ($urandom_range(0, 5) == 0)
            wait_for_answers();
    endtask

    // Response side: runs of taking and stalling, or a long hold on request.
    initial
    begin : rsp_side
        int   run_left;
        logic run_stall;
        rsp_stall = 1'b0;
        run_left  = 0;
        run_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                hold_rsp  = 1'b0;
                run_stall = 1'b1;
                run_left  = HOLD_CYCLES;
            end
            else if (run_left <= 0)
            begin
                if (no_idle)
                begin
                    run_stall = 1'b0;
                    run_left  = 1;
                end
                else
                begin
                    run_stall = ($urandom_range(0, 2) == 0);
                    run_left  = run_stall ? pick_stall() : $urandom_range(1, 12);
                end
            end
            rsp_stall <= run_stall;
            run_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.apply_request(opcode_t'(opcode), new_key, new_payload);
            if (rsp_valid && !rsp_stall)
                sb.check_response(out_valid, out_key, out_payload, status, fill_count);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_sorted_insert_priority_queue_core NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        sb          = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        opcode      = OP_INSERT;
        new_key     = '0;
        new_payload = '0;
        no_idle     = 1'b0;
        hold_rsp    = 1'b0;
        items_sent  = 0;
        idle_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Remove from an empty queue, extremes of key and payload, and a run
        // of equal keys that must leave in arrival order.
        send_item(OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 16'h0000, 32'h0000_0000);
        send_item(OP_INSERT, 16'h8000, 32'hA5A5_A5A5);
        send_item(OP_INSERT, 16'h8000, 32'h5A5A_5A5A);
        send_item(OP_INSERT, 16'h8000, 32'h0000_0001);
        send_item(OP_INSERT, 16'h0000, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 16'h7FFF, 32'h8000_0000);
        repeat (8) send_item(OP_REMOVE, pick_key(0), $urandom);
        wait_for_answers();

        pressure_burst();
        while (items_sent < TARGET_ITEMS)
            run_phase();

        wait_for_answers();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_sorted_insert_priority_queue_core OK");
        else
            $display("tb_sorted_insert_priority_queue_core NOT OK");
        $finish;
    end

endmodule
